>>> rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg
// Types, codes and sizing for the handshake connection table.
// ----------------------------------------------------------------------------
`default_nettype none

package hct_pkg;

    // Number of table entries (1 to 8)
    localparam int TABLE_DEPTH = 8;
    localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Request modes
    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_ACCEPT  = 2'd1;
    localparam logic [1:0] MODE_CLOSE   = 2'd2;
    localparam logic [1:0] MODE_SEGMENT = 2'd3;

    // Segment types
    localparam logic [1:0] SEG_SYN = 2'd0;
    localparam logic [1:0] SEG_FIN = 2'd1;

    // Reply types
    localparam logic REPLY_SYNACK = 1'b0;
    localparam logic REPLY_FINACK = 1'b1;

    // Connection states
    localparam logic [1:0] CONN_CLOSED    = 2'd0;
    localparam logic [1:0] CONN_LISTENING = 2'd1;
    localparam logic [1:0] CONN_CONNECTED = 2'd2;
    localparam logic [1:0] CONN_CLOSEWAIT = 2'd3;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_FULL     = 3'd1;
    localparam logic [2:0] STS_EMPTY    = 3'd2;
    localparam logic [2:0] STS_BUSY     = 3'd3;
    localparam logic [2:0] STS_NO_MATCH = 3'd4;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  socket_id;
        logic [15:0] listen_port;
        logic [1:0]  seg_type;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dest_port;
        logic [31:0] seg_seq;
    } hct_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  entry_index;
        logic [1:0]  entry_state;
        logic        reply_valid;
        logic        reply_type;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dest_port;
        logic [31:0] reply_ack;
    } hct_out_t;

endpackage

`default_nettype wire

>>> rtl/handshake_connection_table.sv
// ----------------------------------------------------------------------------
// handshake_connection_table
// Server-side connection table with create, accept, close and segment lookup.
// ----------------------------------------------------------------------------
// One item is taken at a time. Create and incoming-segment items walk the
// table one entry per cycle through a single port comparator, stopping at the
// first hit. Accept and close address their entry directly and go straight
// to the finish step. s_ready is high only while the sequencer is idle; a
// finished result sits in the output register, so the next item may be
// taken before m_ready returns. No clearing pass is needed after reset: only
// the per-entry used bits are reset, and every other field is written by
// create before it can be read. Remote port and expected sequence are
// carried out in the reply fields and are not kept in the table, as nothing
// reads them back.
// ----------------------------------------------------------------------------
`default_nettype none

module handshake_connection_table (
    input  wire                 aclk,
    input  wire                 aresetn,
    // item input
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire hct_pkg::hct_in_t s_data,
    // result output
    output logic                m_valid,
    input  wire                 m_ready,
    output hct_pkg::hct_out_t   m_data
);

    localparam logic [hct_pkg::PTR_W-1:0] PTR_LAST = hct_pkg::PTR_W'(hct_pkg::TABLE_DEPTH - 1);

    // sequencer
    hct_pkg::ctrl_state_t state_reg, state_next;
    logic [hct_pkg::PTR_W-1:0] ptr_reg, ptr_next;   // scan pointer / addressed entry
    logic hit_reg, hit_next;                        // scan hit or socket_id in range
    hct_pkg::hct_in_t item_reg;

    // table
    logic [hct_pkg::TABLE_DEPTH-1:0] used_reg;
    logic [1:0]  cstate_reg [hct_pkg::TABLE_DEPTH];
    logic [15:0] lport_reg  [hct_pkg::TABLE_DEPTH];

    // output register
    logic              m_valid_reg;
    hct_pkg::hct_out_t m_data_reg;

    // entry read at the pointer: the one read port of the table
    logic        rd_used;
    logic [1:0]  rd_state;
    logic [15:0] rd_lport;
    logic        scan_hit;
    logic        fin_go;
    logic        sid_in_range;

    // finish datapath
    hct_pkg::hct_out_t res;
    logic        used_set, used_clr, cs_we, lp_we;
    logic [1:0]  cs_wdata;
    logic        entry_ok;
    logic [31:0] ack;

    assign rd_used  = used_reg[ptr_reg];
    assign rd_state = cstate_reg[ptr_reg];
    assign rd_lport = lport_reg[ptr_reg];

    // create looks for a free entry, a segment for a used entry on its port
    assign scan_hit = (item_reg.mode == hct_pkg::MODE_CREATE) ? !rd_used
                    : (rd_used && (rd_lport == item_reg.seg_dest_port));

    assign fin_go = (state_reg == hct_pkg::CS_FINISH) && (!m_valid_reg || m_ready);
    assign sid_in_range = (32'(s_data.socket_id) < hct_pkg::TABLE_DEPTH);

    assign s_ready = (state_reg == hct_pkg::CS_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            hct_pkg::CS_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == hct_pkg::MODE_ACCEPT
                        || s_data.mode == hct_pkg::MODE_CLOSE) begin
                        ptr_next   = hct_pkg::PTR_W'(s_data.socket_id);
                        hit_next   = sid_in_range;
                        state_next = hct_pkg::CS_FINISH;
                    end else begin
                        ptr_next   = '0;
                        hit_next   = 1'b0;
                        state_next = hct_pkg::CS_SCAN;
                    end
                end
            end
            hct_pkg::CS_SCAN: begin
                priority if (scan_hit) begin
                    hit_next   = 1'b1;
                    state_next = hct_pkg::CS_FINISH;
                end else if (ptr_reg == PTR_LAST) begin
                    hit_next   = 1'b0;
                    state_next = hct_pkg::CS_FINISH;
                end else begin
                    ptr_next = ptr_reg + hct_pkg::PTR_W'(1);
                end
            end
            hct_pkg::CS_FINISH: begin
                if (fin_go) begin
                    state_next = hct_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = hct_pkg::CS_IDLE;
            end
        endcase
    end

    // result and table updates for the item in hand
    always_comb begin
        res      = '0;
        used_set = 1'b0;
        used_clr = 1'b0;
        cs_we    = 1'b0;
        lp_we    = 1'b0;
        cs_wdata = rd_state;
        entry_ok = hit_reg && rd_used;
        ack      = item_reg.seg_seq + 32'd1;
        unique case (item_reg.mode)
            hct_pkg::MODE_CREATE: begin
                if (hit_reg) begin
                    used_set        = 1'b1;
                    cs_we           = 1'b1;
                    lp_we           = 1'b1;
                    cs_wdata        = hct_pkg::CONN_CLOSED;
                    res.status      = hct_pkg::STS_OK;
                    res.entry_index = 3'(ptr_reg);
                    res.entry_state = hct_pkg::CONN_CLOSED;
                end else begin
                    res.status = hct_pkg::STS_FULL;
                end
            end
            hct_pkg::MODE_ACCEPT, hct_pkg::MODE_CLOSE: begin
                res.entry_index = item_reg.socket_id;
                priority if (!entry_ok) begin
                    res.status = hct_pkg::STS_EMPTY;
                end else if (item_reg.mode == hct_pkg::MODE_ACCEPT) begin
                    cs_we           = 1'b1;
                    cs_wdata        = hct_pkg::CONN_LISTENING;
                    res.entry_state = hct_pkg::CONN_LISTENING;
                end else if (rd_state == hct_pkg::CONN_LISTENING
                             || rd_state == hct_pkg::CONN_CONNECTED) begin
                    res.status      = hct_pkg::STS_BUSY;
                    res.entry_state = rd_state;
                end else begin
                    used_clr        = 1'b1;
                    res.entry_state = hct_pkg::CONN_CLOSED;
                end
            end
            hct_pkg::MODE_SEGMENT: begin
                if (hit_reg) begin
                    priority if ((rd_state == hct_pkg::CONN_LISTENING
                                  || rd_state == hct_pkg::CONN_CONNECTED)
                                 && item_reg.seg_type == hct_pkg::SEG_SYN) begin
                        res.reply_valid = 1'b1;
                        res.reply_type  = hct_pkg::REPLY_SYNACK;
                        cs_we           = 1'b1;
                        cs_wdata        = hct_pkg::CONN_CONNECTED;
                    end else if (rd_state == hct_pkg::CONN_CONNECTED
                                 && item_reg.seg_type == hct_pkg::SEG_FIN) begin
                        res.reply_valid = 1'b1;
                        res.reply_type  = hct_pkg::REPLY_FINACK;
                        cs_we           = 1'b1;
                        cs_wdata        = hct_pkg::CONN_CLOSEWAIT;
                    end else if (rd_state == hct_pkg::CONN_CLOSEWAIT
                                 && item_reg.seg_type == hct_pkg::SEG_FIN) begin
                        res.reply_valid = 1'b1;
                        res.reply_type  = hct_pkg::REPLY_FINACK;
                    end else begin
                        res.reply_valid = 1'b0;
                    end
                    if (res.reply_valid) begin
                        res.reply_src_port  = item_reg.seg_dest_port;
                        res.reply_dest_port = item_reg.seg_src_port;
                        res.reply_ack       = ack;
                    end
                    res.status      = hct_pkg::STS_OK;
                    res.entry_index = 3'(ptr_reg);
                    res.entry_state = cs_wdata;
                end else begin
                    res.status = hct_pkg::STS_NO_MATCH;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hct_pkg::CS_IDLE;
            ptr_reg     <= '0;
            hit_reg     <= 1'b0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            hit_reg   <= hit_next;
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fin_go && used_set) begin
                used_reg[ptr_reg] <= 1'b1;
            end
            if (fin_go && used_clr) begin
                used_reg[ptr_reg] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (fin_go) begin
            m_data_reg <= res;
        end
        if (fin_go && cs_we) begin
            cstate_reg[ptr_reg] <= cs_wdata;
        end
        if (fin_go && lp_we) begin
            lport_reg[ptr_reg] <= item_reg.listen_port;
        end
    end

`ifndef SYNTHESIS
    // a reply only ever goes with a good status
    a_reply_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.reply_valid) |-> (m_data.status == hct_pkg::STS_OK))
        else $error("reply issued with error status");

    // used bits change only when an item completes
    a_used_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !fin_go |=> $stable(used_reg))
        else $error("used bits changed outside completion");

    // a new result appears only out of the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == hct_pkg::CS_FINISH))
        else $error("result raised without finish step");

    // an accepted item always leaves idle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != hct_pkg::CS_IDLE))
        else $error("sequencer stayed idle after accepting an item");
`endif

endmodule

`default_nettype wire

>>> verif/connection_table_checker.sv
// ----------------------------------------------------------------------------
// connection_table_checker
// Watches both channels of the connection table and predicts every result
// from its own copy of the table. Each result is compared field by field
// with the oldest prediction. Failures and coverage counts go to the top.
// ----------------------------------------------------------------------------
module connection_table_checker
    import hct_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_valid,
    input  wire      s_ready,
    input  hct_in_t  s_data,
    input  wire      m_valid,
    input  wire      m_ready,
    input  hct_out_t m_data,
    output int       fail_count,
    output int       pending_count,
    output int       checked_count,
    output int       synack_count,
    output int       finack_count,
    output int       refused_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow table: remote port and expected sequence are taken from each
    // segment request itself, so only what the outcome depends on is kept.
    bit          slot_used  [TABLE_DEPTH];
    logic [1:0]  slot_state [TABLE_DEPTH];
    logic [15:0] slot_port  [TABLE_DEPTH];

    hct_out_t    outcome_fifo [$];
    hct_out_t    want;

    // Applies one request to the shadow table and returns its outcome.
    function automatic hct_out_t apply_request(input hct_in_t rq);
        hct_out_t    r;
        int          hit;
        int          i;
        logic [1:0]  st;
        r   = '0;
        hit = -1;
        case (rq.mode)
            MODE_CREATE: begin
                for (i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && !slot_used[i]) hit = i;
                if (hit < 0) begin
                    r.status = STS_FULL;
                end else begin
                    slot_used[hit]  = 1'b1;
                    slot_state[hit] = CONN_CLOSED;
                    slot_port[hit]  = rq.listen_port;
                    r.entry_index   = 3'(hit);
                    r.entry_state   = CONN_CLOSED;
                end
            end
            MODE_ACCEPT, MODE_CLOSE: begin
                r.entry_index = rq.socket_id;
                if (int'(rq.socket_id) >= TABLE_DEPTH || !slot_used[rq.socket_id]) begin
                    r.status = STS_EMPTY;
                end else if (rq.mode == MODE_ACCEPT) begin
                    slot_state[rq.socket_id] = CONN_LISTENING;
                    r.entry_state            = CONN_LISTENING;
                end else if (slot_state[rq.socket_id] == CONN_LISTENING ||
                             slot_state[rq.socket_id] == CONN_CONNECTED) begin
                    r.status      = STS_BUSY;
                    r.entry_state = slot_state[rq.socket_id];
                end else begin
                    slot_used[rq.socket_id] = 1'b0;
                    r.entry_state           = CONN_CLOSED;
                end
            end
            default: begin
                for (i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && slot_used[i] && slot_port[i] == rq.seg_dest_port) hit = i;
                if (hit < 0) begin
                    r.status = STS_NO_MATCH;
                end else begin
                    st = slot_state[hit];
                    if ((st == CONN_LISTENING || st == CONN_CONNECTED) &&
                        rq.seg_type == SEG_SYN) begin
                        r.reply_valid   = 1'b1;
                        r.reply_type    = REPLY_SYNACK;
                        slot_state[hit] = CONN_CONNECTED;
                    end else if (st == CONN_CONNECTED && rq.seg_type == SEG_FIN) begin
                        r.reply_valid   = 1'b1;
                        r.reply_type    = REPLY_FINACK;
                        slot_state[hit] = CONN_CLOSEWAIT;
                    end else if (st == CONN_CLOSEWAIT && rq.seg_type == SEG_FIN) begin
                        r.reply_valid = 1'b1;
                        r.reply_type  = REPLY_FINACK;
                    end
                    if (r.reply_valid) begin
                        r.reply_src_port  = rq.seg_dest_port;
                        r.reply_dest_port = rq.seg_src_port;
                        r.reply_ack       = rq.seg_seq + 32'd1;
                    end
                    r.entry_index = 3'(hit);
                    r.entry_state = slot_state[hit];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        // printing capped to keep a broken run readable; all are counted
        if (fail_count <= 40) $display("MISMATCH t=%0t %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("result %0d: %s is %0h, predicted %0h",
                                      checked_count, name, got, want_v));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            outcome_fifo.delete();
            pending_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_fifo.size() == 0) begin
                    report_mismatch($sformatf("result with status %0d and nothing outstanding",
                                              m_data.status));
                end else begin
                    want = outcome_fifo.pop_front();
                    compare_field("status",          32'(m_data.status),
                                  32'(want.status));
                    compare_field("entry_index",     32'(m_data.entry_index),
                                  32'(want.entry_index));
                    compare_field("entry_state",     32'(m_data.entry_state),
                                  32'(want.entry_state));
                    compare_field("reply_valid",     32'(m_data.reply_valid),
                                  32'(want.reply_valid));
                    compare_field("reply_type",      32'(m_data.reply_type),
                                  32'(want.reply_type));
                    compare_field("reply_src_port",  32'(m_data.reply_src_port),
                                  32'(want.reply_src_port));
                    compare_field("reply_dest_port", 32'(m_data.reply_dest_port),
                                  32'(want.reply_dest_port));
                    compare_field("reply_ack",       m_data.reply_ack,       want.reply_ack);
                    checked_count++;
                    if (want.reply_valid && want.reply_type == REPLY_SYNACK) synack_count++;
                    if (want.reply_valid && want.reply_type == REPLY_FINACK) finack_count++;
                    if (want.status != STS_OK) refused_count++;
                end
            end
            if (s_valid && s_ready) outcome_fifo.push_back(apply_request(s_data));
            pending_count = outcome_fifo.size();
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the connection table with a directed pass through every state and
// error path, then random connection lifecycles mixed with noise requests,
// under random idling on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hct_pkg::*;

    // segment types the table treats as neither SYN nor FIN
    localparam logic [1:0] SEG_OTHER    = 2'd2;
    localparam logic [1:0] SEG_RESERVED = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int NOISE_ITEMS  = 60;
    localparam int PORT_POOL    = 10;
    localparam int HOLD_CYCLES  = 300;
    // Slowest legal gap between handshakes: the long hold-off plus a full
    // table scan and a sender gap. Taken several times over.
    localparam int STALL_LIMIT  = 2000;
    // Drain margin after the last result, scaled from the table depth.
    localparam int DRAIN_CYCLES = 3 * (TABLE_DEPTH + 2);
    // Window (in cycles) with no idling on either side.
    localparam int QUIET_FROM   = 4000;
    localparam int QUIET_TO     = 5500;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    hct_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    hct_out_t m_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int synack_count;
    int finack_count;
    int refused_count;

    int       cyc;
    int       items_sent;
    int       results_seen;
    hct_out_t last_result;
    bit       hold_req;
    bit       hold_done;

    // Stimulus bookkeeping only: which port was created in which entry, so
    // that lifecycles can address the right entry. Not used for checking.
    logic [15:0] port_pool  [PORT_POOL];
    logic [15:0] slot_port  [TABLE_DEPTH];
    bit          slot_known [TABLE_DEPTH];
    int          known_slots;

    handshake_connection_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    connection_table_checker table_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .synack_count  (synack_count),
        .finack_count  (finack_count),
        .refused_count (refused_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) cyc <= cyc + 1;

    // Result tap: lets a lifecycle learn which entry its create claimed.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            last_result  <= m_data;
        end
    end

    function automatic bit no_idle_window();
        return cyc >= QUIET_FROM && cyc < QUIET_TO;
    endfunction

    // ---- item builders: unused fields stay random so the block must ignore them
    function automatic hct_in_t scrambled();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(hct_in_t)-1:0];
    endfunction

    function automatic hct_in_t create_req(input logic [15:0] port);
        hct_in_t r;
        r             = scrambled();
        r.mode        = MODE_CREATE;
        r.listen_port = port;
        return r;
    endfunction

    function automatic hct_in_t slot_req(input logic [1:0] mode, input logic [2:0] sid);
        hct_in_t r;
        r           = scrambled();
        r.mode      = mode;
        r.socket_id = sid;
        return r;
    endfunction

    function automatic hct_in_t segment_req(input logic [1:0] kind, input logic [15:0] src,
                                            input logic [15:0] dst, input logic [31:0] seq);
        hct_in_t r;
        r               = scrambled();
        r.mode          = MODE_SEGMENT;
        r.seg_type      = kind;
        r.seg_src_port  = src;
        r.seg_dest_port = dst;
        r.seg_seq       = seq;
        return r;
    endfunction

    // mostly ports from the pool so that segments find their entry
    function automatic logic [15:0] pick_port();
        if ($urandom_range(99) < 85) return port_pool[$urandom_range(PORT_POOL - 1)];
        return 16'($urandom());
    endfunction

    // sequence wrap-around and zero get extra weight
    function automatic logic [31:0] pick_seq();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 32'hFFFF_FFFF;
        if (r < 15) return 32'h0;
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40) return SEG_SYN;
        if (r < 80) return SEG_FIN;
        if (r < 90) return SEG_OTHER;
        return SEG_RESERVED;
    endfunction

    function automatic hct_in_t noise_req();
        int r;
        r = $urandom_range(99);
        if (r < 20) return create_req(pick_port());
        if (r < 40) return slot_req(MODE_ACCEPT, 3'($urandom()));
        if (r < 55) return slot_req(MODE_CLOSE, 3'($urandom()));
        return segment_req(pick_kind(), 16'($urandom()), pick_port(), pick_seq());
    endfunction

    // Offers one item: an optional idle gap, then valid held until accepted.
    // Called and returning at a falling edge, with valid dropped afterwards.
    task automatic offer(input hct_in_t item);
        int gap;
        gap = 0;
        if (!no_idle_window() && $urandom_range(99) < 30) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // ---- result side: random stalls, a quiet window, one long hold-off
    initial begin : result_sink
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready = 1'b0;
            end else if (hold_req && !hold_done) begin
                // sender keeps offering meanwhile, so the block fills and
                // drops s_ready
                m_ready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready = no_idle_window() || ($urandom_range(99) >= 12);
            end
        end
    end

    // ---- watchdog: ends the run if no handshake happens for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stalled = 0;
            else stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---- stimulus
    initial begin : stimulus
        int          s;
        int          k;
        int          base;
        logic [15:0] p;

        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        hold_req = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // -- directed: empty table first
        offer(segment_req(SEG_SYN, 16'h1111, 16'h0050, 32'h0000_0010)); // no match
        offer(slot_req(MODE_ACCEPT, 3'd0));                           // empty entry
        offer(slot_req(MODE_CLOSE, 3'd7));                            // empty entry

        // fill the table, port extremes and one duplicate port
        offer(create_req(16'h0000));
        offer(create_req(16'hFFFF));
        offer(create_req(16'h0050));
        offer(create_req(16'h0050));
        offer(create_req(16'hA5A5));
        offer(create_req(16'h5A5A));
        offer(create_req(16'h1F90));
        offer(create_req(16'h0001));
        offer(create_req(16'h8000));                                  // table full

        // entry 2 walked through every state; entry 3 shadowed behind it
        offer(segment_req(SEG_SYN, 16'h2222, 16'h0050, 32'h0000_0001)); // closed: ignored
        offer(slot_req(MODE_ACCEPT, 3'd2));
        offer(slot_req(MODE_CLOSE, 3'd2));                            // busy while listening
        offer(segment_req(SEG_FIN, 16'h3333, 16'h0050, 32'h0000_0002)); // ignored
        offer(segment_req(SEG_SYN, 16'hFFFF, 16'h0050, 32'hFFFF_FFFF)); // SYNACK, ack wraps
        offer(segment_req(SEG_SYN, 16'h1234, 16'h0050, 32'h0000_0000)); // SYNACK again
        offer(slot_req(MODE_CLOSE, 3'd2));                            // busy while connected
        offer(segment_req(SEG_FIN, 16'h4321, 16'h0050, 32'h7FFF_FFFF)); // FINACK, close-wait
        offer(segment_req(SEG_FIN, 16'h0000, 16'h0050, 32'h1234_5678)); // FINACK in close-wait
        offer(segment_req(SEG_SYN, 16'h5555, 16'h0050, 32'h0000_0003)); // ignored
        offer(segment_req(SEG_RESERVED, 16'h6666, 16'h0050, 32'h0000_0004));
        offer(slot_req(MODE_CLOSE, 3'd2));                            // freed
        offer(segment_req(SEG_OTHER, 16'h7777, 16'h0050, 32'h0000_0005)); // now entry 3

        // accept on a connected entry drops it back to listening
        offer(slot_req(MODE_ACCEPT, 3'd1));
        offer(segment_req(SEG_SYN, 16'hAAAA, 16'hFFFF, 32'h5555_5555));
        offer(slot_req(MODE_ACCEPT, 3'd1));
        offer(create_req(16'h2222));                                  // reuses entry 2

        // -- random part
        foreach (port_pool[i]) port_pool[i] = 16'($urandom());
        base = items_sent;

        // noise under the long result hold-off
        hold_req = 1'b1;
        repeat (NOISE_ITEMS) offer(noise_req());

        // connection lifecycles with random content, noise mixed in
        while (items_sent < base + RANDOM_ITEMS) begin
            if (known_slots == 0 || $urandom_range(2) == 0) begin
                p = pick_port();
                offer(create_req(p));
                // wait for the create's own result to learn its entry
                while (results_seen != items_sent) @(negedge aclk);
                s = int'(last_result.entry_index);
                if (last_result.status != STS_OK) begin
                    // table full: free something with noise and try again
                    repeat (4) offer(noise_req());
                    continue;
                end
                if (!slot_known[s]) known_slots++;
                slot_known[s] = 1'b1;
                slot_port[s]  = p;
            end else begin
                do s = $urandom_range(TABLE_DEPTH - 1); while (!slot_known[s]);
            end
            p = slot_port[s];
            if ($urandom_range(99) < 85) offer(slot_req(MODE_ACCEPT, 3'(s)));
            k = $urandom_range(2);
            repeat (k) offer(segment_req(pick_kind() == SEG_FIN ? SEG_OTHER : SEG_SYN,
                                         16'($urandom()), p, pick_seq()));
            if ($urandom_range(99) < 20) offer(noise_req());
            k = $urandom_range(2);
            repeat (k) offer(segment_req(SEG_FIN, 16'($urandom()), p, pick_seq()));
            if ($urandom_range(99) < 85) offer(slot_req(MODE_CLOSE, 3'(s)));
            if ($urandom_range(99) < 25) offer(noise_req());
        end

        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("summary: %0d requests offered, %0d results compared field by field",
                 items_sent, checked_count);
        $display("summary: %0d SYNACK, %0d FINACK, %0d requests turned away",
                 synack_count, finack_count, refused_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
